// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the page table manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define TLPT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the following cycle, disabled while reset is asserted.
`define TLPT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tlpt_pkg.sv =====
// Package with the constants and types of the two-level page table manager.
package tlpt_pkg;

  localparam int unsigned TableSlotsDef = 4;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned FlagsW        = 12;
  localparam int unsigned OffW          = 12;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned FrameW        = AddrW - OffW;

  typedef enum logic [1:0] {
    FUNC_MAP    = 2'd0,
    FUNC_UNMAP  = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_DIR_CLR,
    ST_IDLE,
    ST_DIR,
    ST_TBL,
    ST_SLOT_CLR,
    ST_MAP_WR
  } state_e;

endpackage

// ===== sv/tlpt_if.sv =====
// Handshake interfaces for the request and result channels.
interface tlpt_req_if;
  import tlpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [AddrW-1:0]  vaddr;
  logic [AddrW-1:0]  paddr;
  logic [FlagsW-1:0] flags;

  modport source (output valid, func, vaddr, paddr, flags, input ready);
  modport sink   (input valid, func, vaddr, paddr, flags, output ready);
endinterface

interface tlpt_rsp_if;
  import tlpt_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic             hit;
  logic [AddrW-1:0] phys_addr;

  modport source (output valid, status, hit, phys_addr, input ready);
  modport sink   (input valid, status, hit, phys_addr, output ready);
endinterface

// ===== sv/tlpt_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module tlpt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tlpt_ctrl.sv =====
// Sequencer that walks the directory and table memories and holds the result register.
module tlpt_ctrl #(
  parameter int unsigned TableSlots = tlpt_pkg::TableSlotsDef,
  parameter int unsigned SlotW      = 2,
  parameter int unsigned DirEntW    = 15,
  parameter int unsigned TblAw      = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tlpt_req_if.sink           req_i,
  tlpt_rsp_if.source         rsp_o,
  // Directory memory port.
  output logic               dir_we_o,
  output logic [tlpt_pkg::IdxW-1:0] dir_waddr_o,
  output logic [DirEntW-1:0] dir_wdata_o,
  output logic [tlpt_pkg::IdxW-1:0] dir_raddr_o,
  input  logic [DirEntW-1:0] dir_rdata_i,
  // Table memory port.
  output logic               tbl_we_o,
  output logic [TblAw-1:0]   tbl_waddr_o,
  output logic [tlpt_pkg::AddrW-1:0] tbl_wdata_o,
  output logic [TblAw-1:0]   tbl_raddr_o,
  input  logic [tlpt_pkg::AddrW-1:0] tbl_rdata_i
);
  import tlpt_pkg::*;

  localparam int unsigned CntW = $clog2(TableSlots + 1);

  state_e              state_q, state_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     used_q, used_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  func_e               func_q, func_d;
  logic [IdxW-1:0]     pd_q, pd_d;
  logic [IdxW-1:0]     pt_q, pt_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  logic [FlagsW-1:0]   flags_q, flags_d;
  logic                ovalid_q, ovalid_d;
  logic                ostatus_q, ostatus_d;
  logic                ohit_q, ohit_d;
  logic [AddrW-1:0]    ophys_q, ophys_d;

  logic                out_free;
  logic                dir_present;
  logic [SlotW-1:0]    dir_slot;
  logic                tbl_hit;
  logic [AddrW-1:0]    map_entry;

  assign out_free    = !ovalid_q || rsp_o.ready;
  assign dir_present = dir_rdata_i[0];
  assign dir_slot    = dir_rdata_i[DirEntW-1 -: SlotW];
  assign tbl_hit     = tbl_rdata_i[0] && (func_q != FUNC_RSVD);
  assign map_entry   = {frame_q, flags_q | OffW'(1)};

  assign dir_raddr_o = (state_q == ST_IDLE) ? req_i.vaddr[AddrW-1 -: IdxW] : pd_q;
  assign tbl_raddr_o = {dir_slot, pt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_DIR_CLR;
      cnt_q    <= '0;
      used_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      used_q   <= used_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    func_q    <= func_d;
    pd_q      <= pd_d;
    pt_q      <= pt_d;
    off_q     <= off_d;
    frame_q   <= frame_d;
    flags_q   <= flags_d;
    ostatus_q <= ostatus_d;
    ohit_q    <= ohit_d;
    ophys_q   <= ophys_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    slot_d      = slot_q;
    func_d      = func_q;
    pd_d        = pd_q;
    pt_d        = pt_q;
    off_d       = off_q;
    frame_d     = frame_q;
    flags_d     = flags_q;
    ovalid_d    = ovalid_q && !rsp_o.ready;
    ostatus_d   = ostatus_q;
    ohit_d      = ohit_q;
    ophys_d     = ophys_q;
    req_i.ready = 1'b0;
    dir_we_o    = 1'b0;
    dir_waddr_o = pd_q;
    dir_wdata_o = {slot_q, flags_q, 1'b1};
    tbl_we_o    = 1'b0;
    tbl_waddr_o = {dir_slot, pt_q};
    tbl_wdata_o = map_entry;

    case (state_q)
      ST_DIR_CLR: begin
        dir_we_o    = 1'b1;
        dir_waddr_o = cnt_q;
        dir_wdata_o = '0;
        cnt_d       = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          func_d  = func_e'(req_i.func);
          pd_d    = req_i.vaddr[AddrW-1 -: IdxW];
          pt_d    = req_i.vaddr[OffW +: IdxW];
          off_d   = req_i.vaddr[OffW-1:0];
          frame_d = req_i.paddr[AddrW-1 -: FrameW];
          flags_d = req_i.flags;
          state_d = ST_DIR;
        end
      end
      ST_DIR: begin
        if (dir_present) begin
          state_d = ST_TBL;
        end else if (func_q == FUNC_MAP && used_q != CntW'(TableSlots)) begin
          // Claim the next slot and record it in the directory.
          slot_d      = used_q[SlotW-1:0];
          used_d      = used_q + 1'b1;
          dir_we_o    = 1'b1;
          dir_wdata_o = {used_q[SlotW-1:0], flags_q, 1'b1};
          cnt_d       = '0;
          state_d     = ST_SLOT_CLR;
        end else if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = (func_q == FUNC_MAP);
          ohit_d    = 1'b0;
          ophys_d   = '0;
          state_d   = ST_IDLE;
        end
      end
      ST_SLOT_CLR: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = {slot_q, cnt_q};
        tbl_wdata_o = '0;
        cnt_d       = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = ST_MAP_WR;
        end
      end
      ST_MAP_WR: begin
        if (out_free) begin
          tbl_we_o    = 1'b1;
          tbl_waddr_o = {slot_q, pt_q};
          ovalid_d    = 1'b1;
          ostatus_d   = 1'b0;
          ohit_d      = 1'b0;
          ophys_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_TBL: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = 1'b0;
          ohit_d    = tbl_hit;
          ophys_d   = (func_q == FUNC_LOOKUP && tbl_hit) ?
                      {tbl_rdata_i[AddrW-1 -: FrameW], off_q} : '0;
          if (func_q == FUNC_MAP) begin
            tbl_we_o = 1'b1;
          end else if (func_q == FUNC_UNMAP && tbl_hit) begin
            tbl_we_o    = 1'b1;
            tbl_wdata_o = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.valid     = ovalid_q;
  assign rsp_o.status    = ostatus_q;
  assign rsp_o.hit       = ohit_q;
  assign rsp_o.phys_addr = ophys_q;

endmodule

// ===== sv/two_level_page_table_manager_top.sv =====
// Top level of the two-level page table manager: sequencer plus directory and table memories.
//
// The block keeps a two-level page table for 32-bit virtual addresses in two
// synchronous memories: a directory of 1024 entries, each holding a present
// bit, the attribute flags given when its table was allocated and a slot
// number, and a table memory of TableSlots slots of 1024 entries each. Each
// request transfer (map, unmap or lookup) yields exactly one result transfer.
// After reset the block clears the directory, one entry a cycle, and takes
// no request during that time. An ordinary request then goes from its
// transfer to its result in order: the directory entry is read, then the
// table entry is read, and then the table entry is written for a map or a
// hit unmap and the result is registered; the order is set by the dependent
// read of the directory memory followed by the table memory.
// A map that has to allocate a new table first clears the 1024 entries of
// the new slot, one a cycle, before the entry is written; this happens at
// most TableSlots times after reset. A map that finds every slot taken
// returns status 1 and changes nothing. The next request may be
// transferred while a finished result still waits on the result channel;
// its own result then waits until the earlier one is taken.
module two_level_page_table_manager_top #(
  parameter int unsigned TableSlots = tlpt_pkg::TableSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlpt_req_if.sink   in_i,
  tlpt_rsp_if.source out_o
);
  import tlpt_pkg::*;

  // Slot number width, at least one bit so that a single slot still has a field.
  localparam int unsigned SlotW   = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  // Directory entry: slot number, flags, present bit.
  localparam int unsigned DirEntW = SlotW + FlagsW + 1;
  // Table address: slot number above the index within the slot.
  localparam int unsigned TblAw   = SlotW + IdxW;
  localparam int unsigned TblDep  = TableSlots * (2 ** IdxW);
  localparam int unsigned DirDep  = 2 ** IdxW;

  logic               dir_we;
  logic [IdxW-1:0]    dir_waddr;
  logic [DirEntW-1:0] dir_wdata;
  logic [IdxW-1:0]    dir_raddr;
  logic [DirEntW-1:0] dir_rdata;
  logic               tbl_we;
  logic [TblAw-1:0]   tbl_waddr;
  logic [AddrW-1:0]   tbl_wdata;
  logic [TblAw-1:0]   tbl_raddr;
  logic [AddrW-1:0]   tbl_rdata;

  // The sequencer owns the handshakes, the slot counter and the result register.
  tlpt_ctrl #(
    .TableSlots (TableSlots),
    .SlotW      (SlotW),
    .DirEntW    (DirEntW),
    .TblAw      (TblAw)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_i),
    .rsp_o       (out_o),
    .dir_we_o    (dir_we),
    .dir_waddr_o (dir_waddr),
    .dir_wdata_o (dir_wdata),
    .dir_raddr_o (dir_raddr),
    .dir_rdata_i (dir_rdata),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata)
  );

  // Directory memory, cleared by the sequencer after reset.
  tlpt_ram #(
    .Width (DirEntW),
    .Depth (DirDep),
    .AddrW (IdxW)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  // Table memory; a slot is cleared when it is allocated.
  tlpt_ram #(
    .Width (AddrW),
    .Depth (TblDep),
    .AddrW (TblAw)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

endmodule

// ===== sv/tlpt_checker.sv =====
// Port-level checker for the page table manager, bound to the top level.
`include "assert_macros.svh"

module tlpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        status_i,
  input logic                        hit_i,
  input logic [tlpt_pkg::AddrW-1:0]  phys_addr_i
);
  import tlpt_pkg::*;

  logic [1:0] pending_q, pending_d;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `TLPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(phys_addr_i) && $stable(hit_i) && $stable(status_i), "result changed while stalled")
  `TLPT_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, out_valid_i && status_i, !hit_i && phys_addr_i == '0, "failed map reports a hit or an address")
  `TLPT_ASSERT_NOW(a_phys_needs_hit, clk_i, rst_ni, out_valid_i && phys_addr_i != '0, hit_i, "address returned without a hit")
  `TLPT_ASSERT_NOW(a_no_spurious, clk_i, rst_ni, out_valid_i, pending_q != 2'd0, "result without a request")
  `TLPT_ASSERT_NOW(a_bounded, clk_i, rst_ni, 1'b1, pending_q != 2'd3, "more than two requests outstanding")

endmodule

bind two_level_page_table_manager_top tlpt_checker u_tlpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .hit_i       (out_o.hit),
  .phys_addr_i (out_o.phys_addr)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench of the two-level page table manager: directed table, then random items.
module tb_top;
  import tlpt_pkg::*;

  // The run is stopped here if the block ever hangs. The slowest correct run
  // is the directory clearing, four table allocations, and some 570 items
  // that each wait out at most the longest gap, the longest stall and the
  // latency of a request, plus the long hold. The limit is several times that.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned EntriesPerTbl = 1024;
  localparam int unsigned RandomItems = 550;
  localparam int unsigned LongHoldLen = 300;
  localparam int unsigned DrainCycles = 16;

  typedef struct {
    func_e             func;
    logic [AddrW-1:0]  vaddr;
    logic [AddrW-1:0]  paddr;
    logic [FlagsW-1:0] flags;
  } page_req_t;

  typedef struct {
    logic             status;
    logic             hit;
    logic [AddrW-1:0] phys;
  } page_rsp_t;

  typedef struct {
    page_req_t req;
    bit        typed;
    page_rsp_t rsp;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  two_level_page_table_manager_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // Clock with a period of 4 time units.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the page tables, kept in step with every accepted request.
  bit               dir_present [EntriesPerTbl];
  int unsigned      dir_slot    [EntriesPerTbl];
  logic [AddrW-1:0] tbl_entries [TableSlotsDef*EntriesPerTbl];
  int unsigned      slots_taken;

  // Results that the block still owes, oldest first.
  page_rsp_t owed_translations[$];
  directed_row_t directed_rows[$];

  int unsigned err_count;
  int unsigned results_seen;
  int unsigned cycle_count;
  bit          steady;

  // Walks the shadow tables for one request, applies its effect and returns
  // the result the block must give for it.
  function automatic page_rsp_t walk_and_update(page_req_t r);
    page_rsp_t   res;
    int unsigned pd;
    int unsigned pt;
    int unsigned idx;
    bit          present;
    res.status = 1'b0;
    res.hit    = 1'b0;
    res.phys   = '0;
    pd         = r.vaddr[31:22];
    pt         = r.vaddr[21:12];
    present    = dir_present[pd];
    idx        = 0;
    if (present) begin
      idx     = dir_slot[pd] * EntriesPerTbl + pt;
      res.hit = tbl_entries[idx][0];
    end
    case (r.func)
      FUNC_MAP: begin
        if (!present) begin
          if (slots_taken >= TableSlotsDef) begin
            res.status = 1'b1;
          end else begin
            // A fresh table starts out with every entry not present.
            for (int i = 0; i < EntriesPerTbl; i++) begin
              tbl_entries[slots_taken*EntriesPerTbl + i] = '0;
            end
            dir_present[pd] = 1'b1;
            dir_slot[pd]    = slots_taken;
            idx             = slots_taken * EntriesPerTbl + pt;
            slots_taken++;
          end
        end
        if (!res.status) begin
          tbl_entries[idx] = {r.paddr[31:12], r.flags | 12'h001};
        end
      end
      FUNC_UNMAP: begin
        if (res.hit) begin
          tbl_entries[idx] = '0;
        end
      end
      FUNC_LOOKUP: begin
        if (res.hit) begin
          res.phys = {tbl_entries[idx][31:12], r.vaddr[11:0]};
        end
      end
      default: begin
        // The spare operation code is ignored and answers with all zeros.
        res.hit = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Idle length for either side: mostly none or short, now and then long,
  // and none at all while a steady stretch is running.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Random requests are aimed mostly at a few directory entries and a few
  // table entries, so that maps are followed by hits, remaps and unmaps;
  // two of the six directory entries can never get a table once the pool is empty.
  function automatic page_req_t make_random_req();
    page_req_t   r;
    int unsigned roll;
    int unsigned pd;
    int unsigned pt;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      r.func = FUNC_MAP;
    end else if (roll < 55) begin
      r.func = FUNC_UNMAP;
    end else if (roll < 95) begin
      r.func = FUNC_LOOKUP;
    end else begin
      r.func = FUNC_RSVD;
    end
    if ($urandom_range(0, 4) == 0) begin
      r.vaddr = $urandom;
    end else begin
      case ($urandom_range(0, 5))
        0:       pd = 0;
        1:       pd = 1;
        2:       pd = 2;
        3:       pd = 1023;
        4:       pd = 3;
        default: pd = 512;
      endcase
      pt = $urandom_range(0, 8);
      if (pt == 8) begin
        pt = 1023;
      end
      r.vaddr = {pd[9:0], pt[9:0], 12'($urandom_range(0, 4095))};
    end
    r.paddr = $urandom;
    r.flags = 12'($urandom_range(0, 4095));
    return r;
  endfunction

  task automatic add_row(input func_e f, input logic [AddrW-1:0] va,
                         input logic [AddrW-1:0] pa, input logic [FlagsW-1:0] fl,
                         input bit typed, input logic st, input logic ht,
                         input logic [AddrW-1:0] ph);
    directed_row_t row;
    row.req.func  = f;
    row.req.vaddr = va;
    row.req.paddr = pa;
    row.req.flags = fl;
    row.typed     = typed;
    row.rsp.status = st;
    row.rsp.hit    = ht;
    row.rsp.phys   = ph;
    directed_rows.push_back(row);
  endtask

  // Offers one request from the current falling edge until it is taken,
  // records what it must answer, and returns at the next falling edge.
  task automatic offer_req(input page_req_t r, input bit typed, input page_rsp_t typed_rsp);
    page_rsp_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.func  <= r.func;
    req_ch.vaddr <= r.vaddr;
    req_ch.paddr <= r.paddr;
    req_ch.flags <= r.flags;
    @(posedge clk_i);
    while (!req_ch.ready) begin
      @(posedge clk_i);
    end
    predicted = walk_and_update(r);
    owed_translations.push_back(typed ? typed_rsp : predicted);
    @(negedge clk_i);
  endtask

  // Idles the request side for a random gap, starting at a falling edge.
  task automatic request_gap();
    int unsigned gap;
    gap = pick_idle();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Run guard: a hung block ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side. Ready is changed only at falling edges, once per edge. After
  // 150 results it is held low for a long stretch so that a result backs up,
  // the next request waits behind it and the request channel stalls.
  initial begin : result_sink
    int unsigned stall_left;
    bit          long_hold_due;
    rsp_ch.ready  = 1'b0;
    stall_left    = 0;
    long_hold_due = 1'b1;
    forever begin
      @(negedge clk_i);
      if (long_hold_due && results_seen >= 150) begin
        stall_left    = LongHoldLen;
        long_hold_due = 1'b0;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  // Each result transfer is checked against the oldest owed result.
  always @(posedge clk_i) begin
    page_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      results_seen <= results_seen + 1;
      if (owed_translations.size() == 0) begin
        $error("result transfer with nothing owed: status=%0b hit=%0b phys_addr=%08h",
               rsp_ch.status, rsp_ch.hit, rsp_ch.phys_addr);
        err_count++;
      end else begin
        want = owed_translations.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
          err_count++;
        end
        if (rsp_ch.phys_addr !== want.phys) begin
          $error("phys_addr: expected %08h, got %08h", want.phys, rsp_ch.phys_addr);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    page_rsp_t none;
    page_req_t r;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_MAP;
    req_ch.vaddr = '0;
    req_ch.paddr = '0;
    req_ch.flags = '0;
    err_count    = 0;
    results_seen = 0;
    cycle_count  = 0;
    steady       = 1'b0;
    slots_taken  = 0;
    none.status  = 1'b0;
    none.hit     = 1'b0;
    none.phys    = '0;
    foreach (dir_present[i]) begin
      dir_present[i] = 1'b0;
      dir_slot[i]    = 0;
    end

    // Directed table. Rows with a typed result check it directly; the rest
    // are left to the shadow tables.
    //       op           vaddr         paddr         flags   typed st  hit phys
    add_row(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_UNMAP,  32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_RSVD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1, 0, 0, 32'h0000_0000);
    // First map allocates a table for directory entry 0.
    add_row(FUNC_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 12'h000, 1, 0, 1, 32'hFFFF_FFFF);
    // Remap over a present entry overwrites it and reports a hit.
    add_row(FUNC_MAP,    32'h0000_0000, 32'h1234_5678, 12'h000, 1, 0, 1, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'h0000_0ABC, 32'h0000_0000, 12'h000, 1, 0, 1, 32'h1234_5ABC);
    // The spare code reports nothing even on a present entry.
    add_row(FUNC_RSVD,   32'h0000_0000, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_UNMAP,  32'h0000_0000, 32'h0000_0000, 12'h000, 1, 0, 1, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_UNMAP,  32'h0000_0000, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    // Top directory entry, top table entry, and a fresh table reads empty.
    add_row(FUNC_MAP,    32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1, 0, 1, 32'h0000_0FFF);
    add_row(FUNC_LOOKUP, 32'hFFC0_0123, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    // The last two tables of the pool.
    add_row(FUNC_MAP,    32'h0040_0000, 32'hAAAA_A000, 12'h555, 0, 0, 0, 32'h0000_0000);
    add_row(FUNC_MAP,    32'h0080_1000, 32'h5555_5FFF, 12'hAAA, 0, 0, 0, 32'h0000_0000);
    // Pool exhausted: the map fails and leaves the directory alone.
    add_row(FUNC_MAP,    32'h00C0_0000, 32'hFFFF_F000, 12'hFFF, 1, 1, 0, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'h00C0_0000, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_UNMAP,  32'h00C0_0000, 32'h0000_0000, 12'h000, 1, 0, 0, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'h0080_1FFF, 32'h0000_0000, 12'h000, 0, 0, 0, 32'h0000_0000);
    // Tables are kept after their entries are unmapped, so no allocation here.
    add_row(FUNC_MAP,    32'h0000_1000, 32'h0000_1000, 12'h001, 0, 0, 0, 32'h0000_0000);
    add_row(FUNC_LOOKUP, 32'h0040_0800, 32'h0000_0000, 12'h000, 0, 0, 0, 32'h0000_0000);

    // Reset is released at a falling edge. The block then
    // clears its directory and holds ready low until that is done.
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      request_gap();
      offer_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 200) begin
        // The request side pauses until every owed result has come back.
        req_ch.valid <= 1'b0;
        while (owed_translations.size() != 0) begin
          @(negedge clk_i);
        end
      end
      // A stretch in which neither side idles.
      steady = (n >= 300 && n < 360);
      request_gap();
      r = make_random_req();
      offer_req(r, 1'b0, none);
    end

    req_ch.valid <= 1'b0;
    while (owed_translations.size() != 0) begin
      @(posedge clk_i);
    end
    // A drain period to catch any result that should not be there.
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tlpt_pkg.sv
sv/tlpt_if.sv
sv/tlpt_ram.sv
sv/tlpt_ctrl.sv
sv/two_level_page_table_manager_top.sv
sv/tlpt_checker.sv
verif/tb_top.sv
